FILE: hw/rtl/kelt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the keyed expiring light table.
package kelt_pkg;

  localparam logic [1:0] CMD_NEW   = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_LIST  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam int MAX_RESULTS = 32;
  localparam int NW          = 6;    // holds 0..MAX_RESULTS

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        light_key;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        radius_in;
    logic [15:0]        decay_in;
    logic [15:0]        lifetime;
    logic [31:0]        now;
    logic [9:0]         frame_time;
  } req_t;

  typedef struct packed {
    logic [4:0]         slot;
    logic [15:0]        out_key;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [15:0]        out_radius;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] death;
    logic [15:0] radius;
    logic [15:0] decay;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic ready;
    logic start;
    logic scan;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/kelt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel, used for both requests and results.
interface kelt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/kelt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module kelt_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hw/rtl/kelt_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer for the light table.
module kelt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_cmd,
  input  kelt_pkg::sts_t    sts,
  output kelt_pkg::ctl_t    ctl
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_NEW  = 2'd2;

  logic [1:0] state, state_next;
  logic [1:0] cmd;

  always_comb begin
    ctl.ready  = (state == S_IDLE);
    ctl.start  = ctl.ready && req_valid;
    ctl.scan   = (state == S_SCAN);
    ctl.commit = (state == S_NEW) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.start && req_cmd != kelt_pkg::CMD_CLEAR) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = (cmd == kelt_pkg::CMD_NEW) ? S_NEW : S_IDLE;
      end
      S_NEW: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd   <= kelt_pkg::CMD_NEW;
    end else begin
      state <= state_next;
      if (ctl.start) cmd <= req_cmd;
    end
  end
endmodule

FILE: hw/rtl/kelt_dp.sv
`timescale 1ns / 1ps
// Table storage, slot scan, decay arithmetic and result register.
module kelt_dp #(
  parameter int LIGHT_SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  kelt_pkg::ctl_t    ctl,
  input  kelt_pkg::req_t    req_payload,
  input  logic              rsp_ready,
  output logic              rsp_valid,
  output kelt_pkg::rsp_t    rsp_payload,
  output kelt_pkg::sts_t    sts
);
  localparam int AW = $clog2(LIGHT_SLOTS);
  localparam int CW = $clog2(LIGHT_SLOTS + 1);
  localparam logic [CW-1:0] N_SLOTS = CW'(LIGHT_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(LIGHT_SLOTS - 1);
  localparam logic [kelt_pkg::NW-1:0] LAST_N = kelt_pkg::NW'(kelt_pkg::MAX_RESULTS - 1);

  kelt_pkg::req_t   rq;
  logic [CW-1:0]    idx;
  logic [AW-1:0]    pidx;
  logic             pval;
  logic [LIGHT_SLOTS-1:0] vld;
  logic [LIGHT_SLOTS-1:0] lit;
  logic             match_found, exp_found;
  logic [AW-1:0]    match_idx, exp_idx;
  logic [kelt_pkg::NW-1:0] n_out;

  logic [kelt_pkg::ENTRY_W-1:0] ram_q, wr_data;
  logic [AW-1:0]    rd_addr, wr_addr, pick;
  logic             wr_en;
  kelt_pkg::entry_t ent, wb, fresh;
  logic             stall, emit, tick_wb, out_free;
  logic [25:0]      prod;
  logic [15:0]      loss, new_rad;
  logic [LIGHT_SLOTS-1:0] above;

  kelt_ram #(.W(kelt_pkg::ENTRY_W), .D(LIGHT_SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_comb begin
    // never-written and cleared slots read as zero
    ent      = vld[pidx] ? kelt_pkg::entry_t'(ram_q) : '0;
    out_free = !rsp_valid || rsp_ready;
    above    = (lit >> pidx) >> 1;

    emit  = ctl.scan && pval && rq.command == kelt_pkg::CMD_LIST
            && ent.radius != 16'd0 && n_out <= LAST_N;
    stall = emit && !out_free;

    prod    = 26'(rq.frame_time) * 26'(ent.decay);
    loss    = prod[25:10];
    new_rad = (ent.death < rq.now || loss >= ent.radius) ? 16'd0 : ent.radius - loss;
    wb        = ent;
    wb.radius = new_rad;
    tick_wb = ctl.scan && pval && rq.command == kelt_pkg::CMD_TICK && ent.radius != 16'd0;

    pick = match_found ? match_idx : (exp_found ? exp_idx : '0);
    fresh.key    = rq.light_key;
    fresh.death  = rq.now + 32'(rq.lifetime);
    fresh.radius = rq.radius_in;
    fresh.decay  = rq.decay_in;
    fresh.x      = rq.pos_x;
    fresh.y      = rq.pos_y;
    fresh.z      = rq.pos_z;

    rd_addr = stall ? pidx : idx[AW-1:0];
    wr_en   = tick_wb || ctl.commit;
    wr_addr = ctl.commit ? pick : pidx;
    wr_data = ctl.commit ? fresh : wb;

    sts.scan_done = ctl.scan && pval && !stall && pidx == LAST_IDX;
    sts.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      lit       <= '0;
      pval      <= 1'b0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= (emit && !stall) || ctl.commit || (rsp_valid && !rsp_ready);
      if (ctl.start) begin
        idx  <= '0;
        pval <= 1'b0;
        if (req_payload.command == kelt_pkg::CMD_CLEAR) begin
          vld <= '0;
          lit <= '0;
        end
      end else if (ctl.scan && !stall) begin
        pval <= (idx < N_SLOTS);
        if (idx < N_SLOTS) idx <= idx + CW'(1);
      end
      if (tick_wb) lit[pidx] <= (new_rad != 16'd0);
      if (ctl.commit) begin
        vld[pick] <= 1'b1;
        lit[pick] <= (rq.radius_in != 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rq          <= req_payload;
      match_found <= 1'b0;
      exp_found   <= 1'b0;
      n_out       <= '0;
    end
    if (ctl.scan && !stall) pidx <= idx[AW-1:0];
    if (ctl.scan && pval && rq.command == kelt_pkg::CMD_NEW) begin
      if (!match_found && rq.light_key != 16'd0 && ent.key == rq.light_key) begin
        match_found <= 1'b1;
        match_idx   <= pidx;
      end
      if (!exp_found && ent.death < rq.now) begin
        exp_found <= 1'b1;
        exp_idx   <= pidx;
      end
    end
    if (emit && !stall) begin
      n_out                  <= n_out + kelt_pkg::NW'(1);
      rsp_payload.slot       <= 5'(pidx);
      rsp_payload.out_key    <= ent.key;
      rsp_payload.out_x      <= ent.x;
      rsp_payload.out_y      <= ent.y;
      rsp_payload.out_z      <= ent.z;
      rsp_payload.out_radius <= ent.radius;
      rsp_payload.last       <= (n_out == LAST_N) || (above == '0);
    end
    if (ctl.commit) begin
      rsp_payload.slot       <= 5'(pick);
      rsp_payload.out_key    <= rq.light_key;
      rsp_payload.out_x      <= rq.pos_x;
      rsp_payload.out_y      <= rq.pos_y;
      rsp_payload.out_z      <= rq.pos_z;
      rsp_payload.out_radius <= rq.radius_in;
      rsp_payload.last       <= 1'b1;
    end
  end
endmodule

FILE: hw/rtl/keyed_expiring_light_table_core.sv
`timescale 1ns / 1ps
// Top level of the keyed expiring light table.
//
// Channels: req carries one command per request (new light, tick, list,
// clear); rsp carries result items, with last set on the final one of a run.
// Both use valid/ready; a transfer happens when both are high.
// Sequencing: one request at a time. New, tick and list walk every slot once,
// one slot per cycle through the table RAM's registered read port (a list
// stalled by the receiver holds the walk); new then writes the chosen slot
// and reports it. Clear needs no walk.
// Results sit in an output register, so the next request can be taken while
// the last result still waits. A stalled receiver during a list holds the
// walk on the current slot; a new-light request waits for the register.
// Reset empties the table at once through per-slot valid bits; no clearing
// pass is needed and requests are taken in the first cycle after reset.
module keyed_expiring_light_table_core #(
  parameter int LIGHT_SLOTS = 32
) (
  input  logic clk,
  input  logic rst,
  kelt_if.sink   req,
  kelt_if.source rsp
);
  kelt_pkg::ctl_t ctl;
  kelt_pkg::sts_t sts;

  kelt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.payload.command),
    .sts       (sts),
    .ctl       (ctl)
  );

  kelt_dp #(.LIGHT_SLOTS(LIGHT_SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .req_payload (req.payload),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .rsp_payload (rsp.payload),
    .sts         (sts)
  );

  assign req.ready = ctl.ready;

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (ctl.start && req.payload.command == kelt_pkg::CMD_CLEAR) |=> ctl.ready)
    else $error("clear did not return to idle");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (ctl.start && req.payload.command != kelt_pkg::CMD_CLEAR) |=> !ctl.ready)
    else $error("scan request left the block idle");

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    sts.scan_done |-> ctl.scan)
    else $error("scan done outside a scan");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> rsp.valid && rsp.payload.last)
    else $error("new light result not presented");
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the keyed expiring light table: directed and random requests, scoreboarded results.
module tb_top;

  localparam int SLOTS = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kelt_if #(.T(kelt_pkg::req_t)) req ();
  kelt_if #(.T(kelt_pkg::rsp_t)) rsp ();

  keyed_expiring_light_table_core #(.LIGHT_SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // shadow copy of the light table
  logic [15:0] tbl_key [SLOTS];
  logic [31:0] tbl_death [SLOTS];
  logic [15:0] tbl_radius [SLOTS];
  logic [15:0] tbl_decay [SLOTS];
  logic [23:0] tbl_x [SLOTS];
  logic [23:0] tbl_y [SLOTS];
  logic [23:0] tbl_z [SLOTS];

  kelt_pkg::req_t pending_reqs[$];
  kelt_pkg::rsp_t expected_lights[$];
  int errors = 0;
  bit calm = 1'b0;      // no idling on either side
  bit req_acc = 1'b0;   // request taken at the last rising edge
  int stall_len = 0;    // length of the next long receiver stall
  int stall_seq = 0;
  int stall_seen = 0;
  int hold_off = 0;     // long receiver stall, in cycles
  logic [31:0] clock_ms = 32'd1000;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_key[i] = '0; tbl_death[i] = '0; tbl_radius[i] = '0;
      tbl_decay[i] = '0; tbl_x[i] = '0; tbl_y[i] = '0; tbl_z[i] = '0;
    end
  endfunction

  function automatic kelt_pkg::rsp_t light_entry(input int s, input bit fin);
    kelt_pkg::rsp_t r;
    r.slot = s[4:0];
    r.out_key = tbl_key[s];
    r.out_x = tbl_x[s];
    r.out_y = tbl_y[s];
    r.out_z = tbl_z[s];
    r.out_radius = tbl_radius[s];
    r.last = fin;
    return r;
  endfunction

  function automatic void apply_request(input kelt_pkg::req_t q);
    int s;
    int total;
    int n;
    logic [31:0] loss;
    case (q.command)
      kelt_pkg::CMD_NEW: begin
        s = -1;
        if (q.light_key != 16'd0)
          for (int i = 0; i < SLOTS && s < 0; i++)
            if (tbl_key[i] == q.light_key) s = i;
        for (int i = 0; i < SLOTS && s < 0; i++)
          if (tbl_death[i] < q.now) s = i;
        if (s < 0) s = 0;
        tbl_key[s] = q.light_key;
        tbl_x[s] = q.pos_x;
        tbl_y[s] = q.pos_y;
        tbl_z[s] = q.pos_z;
        tbl_radius[s] = q.radius_in;
        tbl_decay[s] = q.decay_in;
        tbl_death[s] = q.now + {16'd0, q.lifetime};
        expected_lights.push_back(light_entry(s, 1'b1));
      end
      kelt_pkg::CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_radius[i] == 16'd0) continue;
          if (tbl_death[i] < q.now) begin
            tbl_radius[i] = '0;
            continue;
          end
          loss = ({22'd0, q.frame_time} * {16'd0, tbl_decay[i]}) >> 10;
          if (loss >= {16'd0, tbl_radius[i]}) tbl_radius[i] = '0;
          else tbl_radius[i] = tbl_radius[i] - loss[15:0];
        end
      end
      kelt_pkg::CMD_LIST: begin
        total = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_radius[i] != 16'd0) total++;
        if (total > kelt_pkg::MAX_RESULTS) total = kelt_pkg::MAX_RESULTS;
        n = 0;
        for (int i = 0; i < SLOTS && n < total; i++) begin
          if (tbl_radius[i] == 16'd0) continue;
          expected_lights.push_back(light_entry(i, n + 1 == total));
          n++;
        end
      end
      default: wipe_table();
    endcase
  endfunction

  function automatic kelt_pkg::req_t make_req(input logic [1:0] cmd);
    kelt_pkg::req_t q;
    q.command = cmd;
    // few keys so matches happen often; sometimes any value
    case ($urandom_range(0, 3))
      0: q.light_key = 16'd0;
      1: q.light_key = 16'($urandom);
      default: q.light_key = 16'($urandom_range(1, 12));
    endcase
    q.pos_x = 24'($urandom);
    q.pos_y = 24'($urandom);
    q.pos_z = 24'($urandom);
    q.radius_in = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    q.decay_in = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
    q.lifetime = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 200)) : 16'($urandom);
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 60);
    q.now = clock_ms;
    q.frame_time = 10'($urandom);
    return q;
  endfunction

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return kelt_pkg::CMD_NEW;
    if (r < 72) return kelt_pkg::CMD_TICK;
    if (r < 97) return kelt_pkg::CMD_LIST;
    return kelt_pkg::CMD_CLEAR;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_acc) begin
      // hold the offered request
    end else if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 27)) begin
      req.payload <= pending_reqs.pop_front();
      req.valid <= 1'b1;
    end else begin
      req.valid <= 1'b0;
    end
  end

  // long receiver stall counter
  always @(negedge clk) begin
    if (stall_seq != stall_seen) begin
      stall_seen <= stall_seq;
      hold_off <= stall_len;
    end else if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_off > 0) rsp.ready <= 1'b0;
    else rsp.ready <= calm || ($urandom_range(0, 99) >= 27);
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    kelt_pkg::rsp_t got;
    kelt_pkg::rsp_t want;
    if (rst) begin
      wipe_table();
      req_acc = 1'b0;
    end else begin
      req_acc = req.valid && req.ready;
      if (req_acc) apply_request(req.payload);
      if (rsp.valid && rsp.ready) begin
        got = rsp.payload;
        if (expected_lights.size() == 0) report("result with nothing expected");
        else begin
          want = expected_lights.pop_front();
          if (got.slot !== want.slot)
            report($sformatf("slot %0d want %0d", got.slot, want.slot));
          if (got.out_key !== want.out_key)
            report($sformatf("key %h want %h", got.out_key, want.out_key));
          if (got.out_x !== want.out_x)
            report($sformatf("x %h want %h", got.out_x, want.out_x));
          if (got.out_y !== want.out_y)
            report($sformatf("y %h want %h", got.out_y, want.out_y));
          if (got.out_z !== want.out_z)
            report($sformatf("z %h want %h", got.out_z, want.out_z));
          if (got.out_radius !== want.out_radius)
            report($sformatf("radius %h want %h", got.out_radius, want.out_radius));
          if (got.last !== want.last)
            report($sformatf("last %b want %b", got.last, want.last));
        end
      end
    end
  end

  initial begin
    kelt_pkg::req_t q;
    // directed: list empty table, extremes, key reuse, expiry, tick clamp, full table, clear
    q = '0; q.command = kelt_pkg::CMD_LIST; pending_reqs.push_back(q);
    q = '0; q.command = kelt_pkg::CMD_NEW; q.light_key = 16'hFFFF;
    q.pos_x = 24'h7FFFFF; q.pos_y = 24'h800000; q.pos_z = 24'hFFFFFF;
    q.radius_in = 16'hFFFF; q.decay_in = 16'hFFFF; q.lifetime = 16'hFFFF;
    q.now = 32'hFFFF_FFFF; q.frame_time = 10'h3FF;
    pending_reqs.push_back(q);
    q.pos_x = 24'h000001; q.now = 32'd5; pending_reqs.push_back(q);   // key match
    q = '0; q.command = kelt_pkg::CMD_NEW; q.radius_in = 16'd100; q.decay_in = 16'd1024;
    q.lifetime = 16'd0; q.now = 32'd0; pending_reqs.push_back(q);     // nothing expired
    q.now = 32'd10; q.lifetime = 16'd20; pending_reqs.push_back(q);   // first expired slot
    q.now = 32'd20; q.light_key = 16'd7; pending_reqs.push_back(q);
    q = '0; q.command = kelt_pkg::CMD_LIST; pending_reqs.push_back(q);
    q = '0; q.command = kelt_pkg::CMD_TICK; q.now = 32'd25; q.frame_time = 10'd1;
    pending_reqs.push_back(q);
    q.frame_time = 10'h3FF; pending_reqs.push_back(q);                // clamp to zero
    q.frame_time = 10'd0; q.now = 32'hFFFF_FFFF; pending_reqs.push_back(q);
    q = '0; q.command = kelt_pkg::CMD_LIST; pending_reqs.push_back(q);
    for (int i = 0; i < 34; i++) begin
      q = make_req(kelt_pkg::CMD_NEW); q.lifetime = 16'hFFFF; q.light_key = 16'd0;
      q.radius_in = 16'(500 + i); q.now = 32'd0;
      pending_reqs.push_back(q);
    end
    q = '0; q.command = kelt_pkg::CMD_LIST; pending_reqs.push_back(q);
    q.command = kelt_pkg::CMD_CLEAR; pending_reqs.push_back(q);
    q.command = kelt_pkg::CMD_LIST; pending_reqs.push_back(q);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // long receiver stall from the start of the directed requests
    stall_len = 300;
    stall_seq++;
    while (pending_reqs.size() != 0) @(posedge clk);

    for (int i = 0; i < 240; i++) begin
      pending_reqs.push_back(make_req(pick_cmd()));
      if (i == 120) calm = 1'b1;
      if (i == 160) calm = 1'b0;
      if (i == 200) begin
        stall_len = 200;
        stall_seq++;
      end
      if (pending_reqs.size() > 4) @(posedge clk);
    end
    while (pending_reqs.size() != 0) @(posedge clk);
    while (expected_lights.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: keyed_expiring_light_table_core.f
hw/rtl/kelt_pkg.sv
hw/rtl/kelt_if.sv
hw/rtl/kelt_ram.sv
hw/rtl/kelt_ctrl.sv
hw/rtl/kelt_dp.sv
hw/rtl/keyed_expiring_light_table_core.sv
tb/sv/tb_top.sv
